// ===== sv/lrupr_pkg.sv =====
package lrupr_pkg;

  // fixed field widths
  localparam int PAGE_W       = 16;
  localparam int FRAME_IDX_W  = 2;
  localparam int COUNT_W      = 32;

  // defaults for the top-level parameters
  localparam int NUM_FRAMES_DEF = 4;
  localparam int AGE_BITS_DEF   = 32;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_OUT
  } state_t;

endpackage

// ===== sv/lru_page_replacement.sv =====
// LRU page replacement over a small set of frames.
// Input channel (in_valid / in_stall): one page reference per word, with
// in_last_reference marking the end of a reference sequence.
// Result channel (out_valid / out_stall): one word per reference giving hit,
// the frame that now holds the page, the evicted page if any, the running
// saturating fault count and the echoed end-of-sequence mark.
// One compare unit walks the frames, one frame per cycle: it checks for a
// match, the first empty frame and the LRU victim, and writes back the
// aged recency and load ages of that frame. An update step then commits the
// chosen frame and loads the output register.
// A new reference is taken only once the last result word has been taken:
// in_stall stays high from acceptance until the result word has been taken.
// When the receiver stalls, the result word holds in the output register
// and no new reference is taken.
// Reset (rst_n low, synchronous) empties all frames, clears the ages and the
// fault count, and leaves the block idle and ready.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int AGE_BITS   = AGE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // reference input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PAGE_W-1:0]      in_page_number,
  input  logic                   in_last_reference,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_hit,
  output logic [FRAME_IDX_W-1:0] out_frame_index,
  output logic                   out_evicted_valid,
  output logic [PAGE_W-1:0]      out_evicted_page,
  output logic [COUNT_W-1:0]     out_fault_total,
  output logic                   out_sequence_done
);

  localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(NUM_FRAMES - 1);
  localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

  // frame storage
  logic [PAGE_W-1:0]   frame_page_r  [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] frame_valid_r;
  logic [AGE_BITS-1:0] recency_age_r [NUM_FRAMES];
  logic [AGE_BITS-1:0] load_age_r    [NUM_FRAMES];
  logic [COUNT_W-1:0]  fault_r;

  // sequencer
  state_t state_r, state_nxt;
  logic   in_take, out_take, scan_last;

  // per-reference working registers
  logic [FRAME_W-1:0]  scan_idx_r;
  logic [PAGE_W-1:0]   page_r;
  logic                done_r;
  logic                found_r;
  logic [FRAME_W-1:0]  found_idx_r;
  logic                empty_r;
  logic [FRAME_W-1:0]  empty_idx_r;
  logic [FRAME_W-1:0]  victim_idx_r;
  logic [AGE_BITS-1:0] victim_rec_r;
  logic [AGE_BITS-1:0] victim_load_r;
  logic [PAGE_W-1:0]   victim_page_r;

  // output register
  logic                out_valid_r;
  logic                out_hit_r;
  logic [FRAME_IDX_W-1:0] out_frame_index_r;
  logic                out_evicted_valid_r;
  logic [PAGE_W-1:0]   out_evicted_page_r;
  logic [COUNT_W-1:0]  out_fault_total_r;
  logic                out_sequence_done_r;

  // shared compare unit inputs: the frame under the scan pointer
  logic                rd_valid;
  logic [PAGE_W-1:0]   rd_page;
  logic [AGE_BITS-1:0] rd_rec, rd_load, rd_rec_aged, rd_load_aged;
  logic                page_match, take_victim;
  logic [FRAME_W-1:0]  sel_slot;
  logic [COUNT_W-1:0]  fault_inc;

  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign scan_last = (scan_idx_r == LAST_FRAME);

  // read the scanned frame
  assign rd_valid = frame_valid_r[scan_idx_r];
  assign rd_page  = frame_page_r[scan_idx_r];
  assign rd_rec   = recency_age_r[scan_idx_r];
  assign rd_load  = load_age_r[scan_idx_r];

  // saturating age increment
  assign rd_rec_aged  = (&rd_rec)  ? rd_rec  : rd_rec  + AGE_ONE;
  assign rd_load_aged = (&rd_load) ? rd_load : rd_load + AGE_ONE;

  // match and victim compare, ties keep the lower index
  assign page_match  = rd_valid && (rd_page == page_r);
  assign take_victim = (scan_idx_r == '0) || (rd_rec > victim_rec_r) ||
                       ((rd_rec == victim_rec_r) && (rd_load > victim_load_r));

  // frame chosen at commit: hit, else first empty, else victim
  assign sel_slot  = found_r ? found_idx_r : (empty_r ? empty_idx_r : victim_idx_r);
  assign fault_inc = (&fault_r) ? fault_r : fault_r + COUNT_W'(1);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_take) begin
      page_r     <= in_page_number;
      done_r     <= in_last_reference;
      scan_idx_r <= '0;
      found_r    <= 1'b0;
      empty_r    <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      scan_idx_r <= scan_idx_r + FRAME_W'(1);
      if (!found_r && page_match) begin
        found_r     <= 1'b1;
        found_idx_r <= scan_idx_r;
      end
      if (!empty_r && !rd_valid) begin
        empty_r     <= 1'b1;
        empty_idx_r <= scan_idx_r;
      end
      if (take_victim) begin
        victim_idx_r  <= scan_idx_r;
        victim_rec_r  <= rd_rec;
        victim_load_r <= rd_load;
        victim_page_r <= rd_page;
      end
    end
  end

  // frame state: aged during the scan, refreshed on a hit or filled on a fault at commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      fault_r       <= '0;
      for (int f = 0; f < NUM_FRAMES; f++) begin
        frame_page_r[f]  <= '0;
        recency_age_r[f] <= '0;
        load_age_r[f]    <= '0;
      end
    end else if (state_r == ST_SCAN) begin
      recency_age_r[scan_idx_r] <= rd_rec_aged;
      load_age_r[scan_idx_r]    <= rd_load_aged;
    end else if (state_r == ST_UPDATE) begin
      recency_age_r[sel_slot] <= AGE_ONE;
      if (!found_r) begin
        frame_page_r[sel_slot]  <= page_r;
        frame_valid_r[sel_slot] <= 1'b1;
        load_age_r[sel_slot]    <= AGE_ONE;
        fault_r                 <= fault_inc;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_UPDATE) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      out_hit_r           <= found_r;
      out_frame_index_r   <= FRAME_IDX_W'(sel_slot);
      out_evicted_valid_r <= !found_r && !empty_r;
      out_evicted_page_r  <= (!found_r && !empty_r) ? victim_page_r : '0;
      out_fault_total_r   <= found_r ? fault_r : fault_inc;
      out_sequence_done_r <= done_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_index_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_fault_total   = out_fault_total_r;
  assign out_sequence_done = out_sequence_done_r;

`ifndef SYNTHESIS
  // an accepted word starts a scan at frame zero
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == ST_SCAN) && (scan_idx_r == '0))
    else $error("scan did not start at frame zero");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  // eviction only once every frame is filled
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_valid |-> &frame_valid_r)
    else $error("eviction while an empty frame exists");

  // fault count never goes down outside reset
  a_fault_mono: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> fault_r >= $past(fault_r))
    else $error("fault count decreased");

  // a fault word always carries a nonzero count
  a_fault_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_fault_total != '0)
    else $error("fault reported with zero count");
`endif

endmodule

// ===== sim/tb_lru_page_replacement.sv =====
`timescale 1ns / 100ps

module tb_lru_page_replacement;
  import lrupr_pkg::*;

  localparam int NF          = NUM_FRAMES_DEF;
  localparam int AW          = AGE_BITS_DEF;
  localparam int RAND_ITEMS  = 1000;
  localparam int DRAIN_EVERY = 300;
  localparam int CYCLE_LIMIT = 400000;

  // one result word as the block reports it
  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [COUNT_W-1:0]     fault_total;
    logic                   sequence_done;
  } access_t;

  // per reference: whether the result is fixed by hand, and that result
  typedef struct packed {
    logic    known;
    access_t want;
  } ref_tag_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last;
    logic              known;
    access_t           want;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [PAGE_W-1:0]      in_page_number;
  logic                   in_last_reference;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_hit;
  logic [FRAME_IDX_W-1:0] out_frame_index;
  logic                   out_evicted_valid;
  logic [PAGE_W-1:0]      out_evicted_page;
  logic [COUNT_W-1:0]     out_fault_total;
  logic                   out_sequence_done;

  // shadow of the frame set
  logic [PAGE_W-1:0]  res_page [NF];
  logic               res_valid [NF];
  logic [AW-1:0]      res_age_ref [NF];
  logic [AW-1:0]      res_age_load [NF];
  logic [COUNT_W-1:0] fault_tally;

  access_t  pending_access_q [$];
  ref_tag_t ref_tag_q [$];
  dir_row_t dir_tab [$];

  int errors;
  int cycle_cnt;
  int burst_left;

  lru_page_replacement u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .in_last_reference (in_last_reference),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .out_sequence_done (out_sequence_done)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // age every frame by one, saturating
  function automatic void bump_ages();
    for (int f = 0; f < NF; f++) begin
      if (res_age_ref[f] != '1) res_age_ref[f] = res_age_ref[f] + 1'b1;
      if (res_age_load[f] != '1) res_age_load[f] = res_age_load[f] + 1'b1;
    end
  endfunction

  // one page reference against the shadow frame set
  function automatic access_t lru_access(input logic [PAGE_W-1:0] page, input logic last);
    access_t r;
    int      slot;
    r    = '0;
    slot = -1;
    // empty frames never match
    for (int f = 0; f < NF; f++)
      if (slot < 0 && res_valid[f] && res_page[f] == page) slot = f;
    if (slot >= 0) begin
      r.hit = 1'b1;
      bump_ages();
      res_age_ref[slot] = 1;
    end else begin
      for (int f = 0; f < NF; f++)
        if (slot < 0 && !res_valid[f]) slot = f;
      // victim: oldest use, then oldest load, then lowest index
      if (slot < 0) begin
        slot = 0;
        for (int f = 1; f < NF; f++)
          if (res_age_ref[f] > res_age_ref[slot] ||
              (res_age_ref[f] == res_age_ref[slot] &&
               res_age_load[f] > res_age_load[slot]))
            slot = f;
        r.evicted_valid = 1'b1;
        r.evicted_page  = res_page[slot];
      end
      bump_ages();
      res_page[slot]     = page;
      res_valid[slot]    = 1'b1;
      res_age_ref[slot]  = 1;
      res_age_load[slot] = 1;
      if (fault_tally != '1) fault_tally = fault_tally + 1'b1;
    end
    r.frame_index   = slot[FRAME_IDX_W-1:0];
    r.fault_total   = fault_tally;
    r.sequence_done = last;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      errors++;
    end
  endfunction

  // watch both handshakes
  always @(posedge clk) begin
    access_t  pred;
    access_t  want;
    ref_tag_t tg;
    if (rst_n === 1'b1) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        pred = lru_access(in_page_number, in_last_reference);
        tg   = ref_tag_q.pop_front();
        pending_access_q.push_back(tg.known ? tg.want : pred);
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_access_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual page %0h total %0h",
                   $realtime, out_evicted_page, out_fault_total);
          errors++;
        end else begin
          want = pending_access_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_hit));
          check_field("frame_index", 32'(want.frame_index), 32'(out_frame_index));
          check_field("evicted_valid", 32'(want.evicted_valid), 32'(out_evicted_valid));
          check_field("evicted_page", 32'(want.evicted_page), 32'(out_evicted_page));
          check_field("fault_total", want.fault_total, out_fault_total);
          check_field("sequence_done", 32'(want.sequence_done), 32'(out_sequence_done));
        end
      end
    end
  end

  // receiver stall pattern, changing mode every so often
  initial begin
    int mode;
    int left;
    out_stall <= 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 1) == 1);
        end
        2: begin
          out_stall <= ($urandom_range(0, 7) != 0);
        end
        default: begin
          out_stall <= ((cycle_cnt % 11) < 4);
        end
      endcase
    end
  end

  task automatic add_row(input logic [PAGE_W-1:0] page, input logic last, input logic known,
                         input logic hit, input logic [FRAME_IDX_W-1:0] idx,
                         input logic evv, input logic [PAGE_W-1:0] evp,
                         input logic [COUNT_W-1:0] total);
    dir_row_t row;
    row.page  = page;
    row.last  = last;
    row.known = known;
    row.want  = {hit, idx, evv, evp, total, last};
    dir_tab.push_back(row);
  endtask

  // drive one reference word, with bursts and gaps, and wait for its acceptance
  task automatic send_ref(input logic [PAGE_W-1:0] page, input logic last, input logic known,
                          input access_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_page_number    <= page;
    in_last_reference <= last;
    ref_tag_q.push_back({known, want});
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // hold off until every result word is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_access_q.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [PAGE_W-1:0] work_set [8];
    logic [PAGE_W-1:0] page;
    logic              last;
    int                sent;
    int                seq_len;
    int                ws_size;

    errors            = 0;
    cycle_cnt         = 0;
    burst_left        = 0;
    fault_tally       = '0;
    for (int f = 0; f < NF; f++) begin
      res_page[f]     = '0;
      res_valid[f]    = 1'b0;
      res_age_ref[f]  = '0;
      res_age_load[f] = '0;
    end
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_page_number    <= '0;
    in_last_reference <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: page 0 into empty frames, all-ones page, a hit on page 0, fill, first eviction
    add_row(16'h0000, 1'b0, 1'b1, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd1);
    add_row(16'hFFFF, 1'b0, 1'b1, 1'b0, 2'd1, 1'b0, 16'h0000, 32'd2);
    add_row(16'h0000, 1'b0, 1'b1, 1'b1, 2'd0, 1'b0, 16'h0000, 32'd2);
    add_row(16'h8000, 1'b0, 1'b1, 1'b0, 2'd2, 1'b0, 16'h0000, 32'd3);
    add_row(16'h0001, 1'b1, 1'b1, 1'b0, 2'd3, 1'b0, 16'h0000, 32'd4);
    add_row(16'h1234, 1'b0, 1'b1, 1'b0, 2'd1, 1'b1, 16'hFFFF, 32'd5);
    // the rest go through the predictor
    add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'h0001, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'h8000, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'h0000, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'h1234, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'h7FFF, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'hAAAA, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'h5555, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'h0001, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'hFFFE, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'h0000, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'h0000, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'h5555, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'h0000, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);
    add_row(16'hFFFF, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 16'h0000, 32'd0);

    foreach (dir_tab[i])
      send_ref(dir_tab[i].page, dir_tab[i].last, dir_tab[i].known, dir_tab[i].want);
    drain();

    // random: sequences drawn mostly from a small working set
    sent = 0;
    while (sent < RAND_ITEMS) begin
      seq_len = $urandom_range(1, 40);
      ws_size = $urandom_range(2, 8);
      for (int k = 0; k < ws_size; k++) begin
        case ($urandom_range(0, 9))
          0: work_set[k] = '0;
          1: work_set[k] = '1;
          default: work_set[k] = PAGE_W'($urandom);
        endcase
      end
      for (int k = 0; k < seq_len; k++) begin
        if ($urandom_range(0, 9) < 7) page = work_set[$urandom_range(0, ws_size - 1)];
        else page = PAGE_W'($urandom);
        // end mark at the end of a sequence, and now and then as noise
        last = (k == seq_len - 1) || ($urandom_range(0, 31) == 0);
        send_ref(page, last, 1'b0, '0);
        sent++;
        if (sent % DRAIN_EVERY == 0) drain();
      end
    end

    // wait out the last word, then a little longer for strays
    drain();
    repeat (NF + 12) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lrupr_pkg.sv
sv/lru_page_replacement.sv
sim/tb_lru_page_replacement.sv
